@@ rtl/msc_pkg.sv @@
// Shared constants, register codes and word functions for the cascade collision checker.
// No dependencies; every other file imports this package.
`default_nettype none

package msc_pkg;

  localparam int WORD_BITS_DEF  = 8;
  localparam int IN_TDATA_BITS  = 32;
  localparam int OUT_TDATA_BITS = 40;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_IDX_BITS   = 8;
  localparam int TAIL_BITS      = 56;

  // Round constants for rounds 57 to 63; the stages keep the low word bits.
  localparam logic [31:0] K57 = 32'h78a5636f;
  localparam logic [31:0] K58 = 32'h84c87814;
  localparam logic [31:0] K59 = 32'h8cc70208;
  localparam logic [31:0] K60 = 32'h90befffa;
  localparam logic [31:0] K61 = 32'ha4506ceb;
  localparam logic [31:0] K62 = 32'hbef9a3f7;
  localparam logic [31:0] K63 = 32'hc67178f2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_A = 8'd0,
    CFG_START_B = 8'd1,
    CFG_TAIL_A  = 8'd2,
    CFG_TAIL_B  = 8'd3
  } cfg_reg_t;

  // Full-size amount scaled to the word width, rounded half to even, at least one.
  function automatic int unsigned scaled(input int unsigned k32, input int unsigned wb);
    int unsigned num;
    int unsigned q;
    int unsigned rem;
    num = k32 * wb;
    q   = num >> 5;
    rem = num & 32'd31;
    if (rem > 32'd16 || (rem == 32'd16 && q[0])) q = q + 32'd1;
    if (q < 32'd1) q = 32'd1;
    return q;
  endfunction

  // Scaled amount reduced modulo the word width (small values, few subtractions).
  function automatic int unsigned amt(input int unsigned k32, input int unsigned wb);
    int unsigned k;
    k = scaled(k32, wb);
    for (int i = 0; i < 8; i++) begin
      if (k >= wb) k = k - wb;
    end
    return k;
  endfunction

  function automatic logic [63:0] wmask(input int unsigned wb);
    return (64'd1 << wb) - 64'd1;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned k,
                                       input int unsigned wb);
    logic [63:0] v;
    v = {32'd0, x} & wmask(wb);
    if (k == 0) return v[31:0];
    return 32'(((v >> k) | (v << (wb - k))) & wmask(wb));
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x, input int unsigned wb);
    return rotr(x, amt(2, wb), wb) ^ rotr(x, amt(13, wb), wb) ^ rotr(x, amt(22, wb), wb);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x, input int unsigned wb);
    return rotr(x, amt(6, wb), wb) ^ rotr(x, amt(11, wb), wb) ^ rotr(x, amt(25, wb), wb);
  endfunction

  function automatic logic [31:0] small0(input logic [31:0] x, input int unsigned wb);
    logic [31:0] v;
    v = x & 32'(wmask(wb));
    return rotr(v, amt(7, wb), wb) ^ rotr(v, amt(18, wb), wb) ^ (v >> amt(3, wb));
  endfunction

  function automatic logic [31:0] small1(input logic [31:0] x, input int unsigned wb);
    logic [31:0] v;
    v = x & 32'(wmask(wb));
    return rotr(v, amt(17, wb), wb) ^ rotr(v, amt(19, wb), wb) ^ (v >> amt(10, wb));
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                     input logic [31:0] g, input int unsigned wb);
    return ((e & f) ^ (~e & g)) & 32'(wmask(wb));
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input int unsigned wb);
    return ((a & b) ^ (a & c) ^ (b & c)) & 32'(wmask(wb));
  endfunction

endpackage

`default_nettype wire

@@ rtl/msc_round_stage.sv @@
// One pipeline stage: a compression round on both instances, with optional cascade word.
// Depends on msc_pkg for the round functions.
`default_nettype none

module msc_round_stage #(
  parameter int          WORD_BITS = msc_pkg::WORD_BITS_DEF,
  parameter logic [31:0] ROUND_K   = 32'h0,
  parameter bit          CASCADE   = 1'b0,
  parameter int          SIDE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [8*WORD_BITS-1:0] in_sa,
  input  logic [8*WORD_BITS-1:0] in_sb,
  input  logic [WORD_BITS-1:0]   in_wa,
  input  logic [WORD_BITS-1:0]   in_wb,
  input  logic [SIDE_BITS-1:0]   in_side,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [8*WORD_BITS-1:0] out_sa,
  output logic [8*WORD_BITS-1:0] out_sb,
  output logic [WORD_BITS-1:0]   out_w,
  output logic [SIDE_BITS-1:0]   out_side
);
  import msc_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] K = ROUND_K[W-1:0];

  function automatic logic [W-1:0] t1_base(input logic [W-1:0] e, input logic [W-1:0] f,
                                           input logic [W-1:0] g, input logic [W-1:0] h);
    return h + W'(big1(32'(e), W)) + W'(ch(32'(e), 32'(f), 32'(g), W)) + K;
  endfunction

  function automatic logic [W-1:0] t2_of(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic [W-1:0] c);
    return W'(big0(32'(a), W)) + W'(maj(32'(a), 32'(b), 32'(c), W));
  endfunction

  logic [W-1:0]   sa [8];
  logic [W-1:0]   sb [8];
  logic [W-1:0]   t1ba, t1bb, t2a, t2b, wb_c, w_b, t1a, t1b;
  logic [8*W-1:0] sa_nxt, sb_nxt;
  logic [8*W-1:0] sa_r, sb_r;
  logic [W-1:0]   w_r;
  logic [SIDE_BITS-1:0] side_r;
  logic           valid_r;
  logic           valid_nxt;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sa[i] = in_sa[i*W +: W];
      sb[i] = in_sb[i*W +: W];
    end
    t1ba = t1_base(sa[4], sa[5], sa[6], sa[7]);
    t1bb = t1_base(sb[4], sb[5], sb[6], sb[7]);
    t2a  = t2_of(sa[0], sa[1], sa[2]);
    t2b  = t2_of(sb[0], sb[1], sb[2]);
    // Second word chosen so that both new 'a' words come out equal.
    wb_c = in_wa + t1ba - t1bb + t2a - t2b;
    w_b  = CASCADE ? wb_c : in_wb;
    t1a  = t1ba + in_wa;
    t1b  = t1bb + w_b;
    sa_nxt = {sa[6], sa[5], sa[4], sa[3] + t1a, sa[2], sa[1], sa[0], t1a + t2a};
    sb_nxt = {sb[6], sb[5], sb[4], sb[3] + t1b, sb[2], sb[1], sb[0], t1b + t2b};
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      sa_r   <= sa_nxt;
      sb_r   <= sb_nxt;
      w_r    <= w_b;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_sa    = sa_r;
  assign out_sb    = sb_r;
  assign out_w     = w_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

@@ rtl/mini_sha_cascade_collision_check.sv @@
// Top level of the cascade collision checker: configuration registers, seven round stages,
// schedule words between stages and the output register. Depends on msc_pkg and msc_round_stage.
`default_nettype none

// The block checks one candidate of four message words (rounds 57 to 60) per word accepted.
// Two instances of the reduced hash start from the configured round-56 states; the second
// instance's words for rounds 57 to 60 are cascade words that make its new 'a' equal to the
// first's. Schedule words 61 to 63 are formed from the configured tail words and earlier
// schedule words. Each of the seven rounds has its own pipeline stage, and a final register
// holds the state compare; a new candidate can be accepted every cycle while the output is
// not stalled. Every stage holds its word while the stage after it is full and stalled, and
// empty stages fill up even when the output is stalled, so a stall loses nothing. The result
// word carries the candidate echo, a filter flag (the 'e' words agree after round 61) and a
// collision flag (all eight words agree after round 63).
// Configuration writes are always taken at once and must only be made while the pipeline is
// empty; indexes beyond the four registers are ignored.
module mini_sha_cascade_collision_check #(
  parameter int WORD_BITS = msc_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // word_r57 [7:0], word_r58 [15:8], word_r59 [23:16], word_r60 [31:24]
  input  logic [msc_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // candidate_echo [31:0], filter_pass [32], collision [33], zeros [39:34]
  output logic [msc_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [msc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import msc_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int ST = 8 * W;

  // Schedule recurrence: sigma1 of a recent word, two older words and sigma0 of a third.
  function automatic logic [W-1:0] sched(input logic [W-1:0] w1, input logic [W-1:0] t_hi,
                                         input logic [W-1:0] t_mid, input logic [W-1:0] t_lo);
    return W'(small1(32'(w1), W)) + t_hi + W'(small0(32'(t_mid), W)) + t_lo;
  endfunction

  // Configuration registers.
  logic [63:0]          start_a_r, start_b_r;
  logic [TAIL_BITS-1:0] tail_a_r, tail_b_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_a_r <= '0;
      start_b_r <= '0;
      tail_a_r  <= '0;
      tail_b_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_A: start_a_r <= cfg_data;
        CFG_START_B: start_b_r <= cfg_data;
        CFG_TAIL_A:  tail_a_r  <= cfg_data[TAIL_BITS-1:0];
        CFG_TAIL_B:  tail_b_r  <= cfg_data[TAIL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Each packed byte becomes one word: truncated for narrow words, zero-extended for wide.
  logic [ST-1:0] start_a_w, start_b_w;
  logic [W-1:0]  ta [7];
  logic [W-1:0]  tb [7];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      start_a_w[i*W +: W] = W'(start_a_r[i*8 +: 8]);
      start_b_w[i*W +: W] = W'(start_b_r[i*8 +: 8]);
    end
    for (int i = 0; i < 7; i++) begin
      ta[i] = W'(tail_a_r[i*8 +: 8]);
      tb[i] = W'(tail_b_r[i*8 +: 8]);
    end
  end

  // The echo keeps round 57 in the top byte.
  logic [31:0] echo_in;
  assign echo_in = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};

  // Stage signals.
  logic          s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v;
  logic          s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, s7_rdy, out_rdy;
  logic [ST-1:0] s1_sa, s1_sb, s2_sa, s2_sb, s3_sa, s3_sb, s4_sa, s4_sb;
  logic [ST-1:0] s5_sa, s5_sb, s6_sa, s6_sb, s7_sa, s7_sb;
  logic [W-1:0]  s3_w, s4_w;
  logic [31:0]   s1_side, s2_side, s3_side;
  logic [2*W+31:0] s4_side_in, s4_side;
  logic [4*W+31:0] s5_side_in, s5_side;
  logic [2*W+32:0] s6_side_in, s6_side;
  logic [32:0]     s7_side_in, s7_side;
  logic [W-1:0]  xa0, xb0, xa1, xb1, xa2, xb2;
  logic          pass_5;

  msc_round_stage #(.WORD_BITS(W), .ROUND_K(K57), .CASCADE(1'b1), .SIDE_BITS(32)) u_r57 (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_sa(start_a_w), .in_sb(start_b_w), .in_wa(W'(in_tdata[7:0])), .in_wb('0),
    .in_side(echo_in), .out_valid(s1_v), .out_ready(s2_rdy),
    .out_sa(s1_sa), .out_sb(s1_sb), .out_w(), .out_side(s1_side)
  );

  msc_round_stage #(.WORD_BITS(W), .ROUND_K(K58), .CASCADE(1'b1), .SIDE_BITS(32)) u_r58 (
    .clk(clk), .rst_n(rst_n), .in_valid(s1_v), .in_ready(s2_rdy),
    .in_sa(s1_sa), .in_sb(s1_sb), .in_wa(W'(s1_side[23:16])), .in_wb('0),
    .in_side(s1_side), .out_valid(s2_v), .out_ready(s3_rdy),
    .out_sa(s2_sa), .out_sb(s2_sb), .out_w(), .out_side(s2_side)
  );

  msc_round_stage #(.WORD_BITS(W), .ROUND_K(K59), .CASCADE(1'b1), .SIDE_BITS(32)) u_r59 (
    .clk(clk), .rst_n(rst_n), .in_valid(s2_v), .in_ready(s3_rdy),
    .in_sa(s2_sa), .in_sb(s2_sb), .in_wa(W'(s2_side[15:8])), .in_wb('0),
    .in_side(s2_side), .out_valid(s3_v), .out_ready(s4_rdy),
    .out_sa(s3_sa), .out_sb(s3_sb), .out_w(s3_w), .out_side(s3_side)
  );

  // Schedule word 61 needs both round-59 words, so it is formed beside round 60.
  assign xa0 = sched(W'(s3_side[15:8]), ta[4], ta[1], ta[0]);
  assign xb0 = sched(s3_w, tb[4], tb[1], tb[0]);
  assign s4_side_in = {xb0, xa0, s3_side};

  msc_round_stage #(.WORD_BITS(W), .ROUND_K(K60), .CASCADE(1'b1), .SIDE_BITS(2*W+32)) u_r60 (
    .clk(clk), .rst_n(rst_n), .in_valid(s3_v), .in_ready(s4_rdy),
    .in_sa(s3_sa), .in_sb(s3_sb), .in_wa(W'(s3_side[7:0])), .in_wb('0),
    .in_side(s4_side_in), .out_valid(s4_v), .out_ready(s5_rdy),
    .out_sa(s4_sa), .out_sb(s4_sb), .out_w(s4_w), .out_side(s4_side)
  );

  // Words 62 and 63 are formed beside round 61.
  assign xa1 = sched(W'(s4_side[7:0]), ta[5], ta[2], ta[1]);
  assign xb1 = sched(s4_w, tb[5], tb[2], tb[1]);
  assign xa2 = sched(s4_side[32 +: W], ta[6], ta[3], ta[2]);
  assign xb2 = sched(s4_side[32+W +: W], tb[6], tb[3], tb[2]);
  assign s5_side_in = {xb2, xa2, xb1, xa1, s4_side[31:0]};

  msc_round_stage #(.WORD_BITS(W), .ROUND_K(K61), .CASCADE(1'b0), .SIDE_BITS(4*W+32)) u_r61 (
    .clk(clk), .rst_n(rst_n), .in_valid(s4_v), .in_ready(s5_rdy),
    .in_sa(s4_sa), .in_sb(s4_sb), .in_wa(s4_side[32 +: W]), .in_wb(s4_side[32+W +: W]),
    .in_side(s5_side_in), .out_valid(s5_v), .out_ready(s6_rdy),
    .out_sa(s5_sa), .out_sb(s5_sb), .out_w(), .out_side(s5_side)
  );

  // Filter: the 'e' words agree after round 61.
  assign pass_5     = (s5_sa[4*W +: W] == s5_sb[4*W +: W]);
  assign s6_side_in = {s5_side[32+2*W +: 2*W], pass_5, s5_side[31:0]};

  msc_round_stage #(.WORD_BITS(W), .ROUND_K(K62), .CASCADE(1'b0), .SIDE_BITS(2*W+33)) u_r62 (
    .clk(clk), .rst_n(rst_n), .in_valid(s5_v), .in_ready(s6_rdy),
    .in_sa(s5_sa), .in_sb(s5_sb), .in_wa(s5_side[32 +: W]), .in_wb(s5_side[32+W +: W]),
    .in_side(s6_side_in), .out_valid(s6_v), .out_ready(s7_rdy),
    .out_sa(s6_sa), .out_sb(s6_sb), .out_w(), .out_side(s6_side)
  );

  assign s7_side_in = s6_side[32:0];

  msc_round_stage #(.WORD_BITS(W), .ROUND_K(K63), .CASCADE(1'b0), .SIDE_BITS(33)) u_r63 (
    .clk(clk), .rst_n(rst_n), .in_valid(s6_v), .in_ready(s7_rdy),
    .in_sa(s6_sa), .in_sb(s6_sb), .in_wa(s6_side[33 +: W]), .in_wb(s6_side[33+W +: W]),
    .in_side(s7_side_in), .out_valid(s7_v), .out_ready(out_rdy),
    .out_sa(s7_sa), .out_sb(s7_sb), .out_w(), .out_side(s7_side)
  );

  // Output register: the full-state compare sits between round 63 and the port.
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_BITS-1:0] out_tdata_r, out_tdata_nxt;
  logic                      coll;

  assign coll          = (s7_sa == s7_sb);
  assign out_rdy       = !out_valid_r || out_tready;
  assign out_valid_nxt = out_rdy ? s7_v : out_valid_r;
  assign out_tdata_nxt = {6'd0, coll, s7_side[32], s7_side[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // A collision needs equal 'e' words after round 61 as well.
  a_coll_implies_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[33] || out_tdata[32]))
    else $error("collision flagged without filter pass");

  // With the output register empty every stage can move, so input is taken.
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output register empty");

  // A result appears only when the last round stage held a word.
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s7_v))
    else $error("result without a word in the last round stage");

  // The padding bits of the result word stay clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:34] == 6'd0))
    else $error("padding bits set in result word");

endmodule

`default_nettype wire
